// ----- sv/key_event_latch_throttle_core_defines.svh -----
// assertion macros shared by the key event core checkers
// no dependencies; expects clk_i and rst_ni in the scope of use
`ifndef KEY_EVENT_LATCH_THROTTLE_CORE_DEFINES_SVH
`define KEY_EVENT_LATCH_THROTTLE_CORE_DEFINES_SVH

// clocked assertion, disabled while reset is held
`define KELT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked assertion that also holds during reset
`define KELT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- sv/kelt_pkg.sv -----
// shared types and constants for the key event latch/throttle core
// no dependencies
package kelt_pkg;

  // key table size, derived address width and field widths
  localparam int unsigned KEYS       = 512;
  localparam int unsigned KEY_W      = 10;
  localparam int unsigned ADDR_W     = (KEYS > 1) ? $clog2(KEYS) : 1;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned INTERVAL_W = 16;

  // operation codes
  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_PRESS   = 2'd1,
    OP_RELEASE = 2'd2,
    OP_CHECK   = 2'd3
  } op_e;

  // one key table entry
  typedef struct packed {
    logic              held;
    logic              sticky;
    logic [TIME_W-1:0] fire_time;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

// ----- sv/kelt_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
module kelt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/key_event_latch_throttle_core.sv -----
// key event latch/throttle core: per-key state table in a ram plus tick counter
// depends on kelt_pkg and kelt_ram
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------
//  command  | start / busy       | op_i, key_i, edge_mode_i, interval_ticks_i
//  result   | valid_o (1 cycle)  | fired_o, error_o
//
// for every command the key's table entry is read from the ram in the transfer cycle; in the
// next one a press, a release or an unthrottled check on a valid key writes it back modified.
// the result strobes in the cycle after the write-back; a new command may be taken in that cycle.
// after reset, busy stays high while all KEYS (512) table entries are cleared.
// results cannot be stalled; each one is shown for exactly one cycle.
module key_event_latch_throttle_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      op_i,
  input  logic [kelt_pkg::KEY_W-1:0]      key_i,
  input  logic                            edge_mode_i,
  input  logic [kelt_pkg::INTERVAL_W-1:0] interval_ticks_i,
  output logic                            valid_o,
  output logic                            fired_o,
  output logic                            error_o
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0] state_q, state_d;
  logic [kelt_pkg::ADDR_W-1:0] clr_cnt_q, clr_cnt_d;
  logic [kelt_pkg::TIME_W-1:0] now_q, now_d;

  kelt_pkg::op_e                   op_q;
  logic [kelt_pkg::ADDR_W-1:0]     addr_q;
  logic                            edge_q;
  logic [kelt_pkg::INTERVAL_W-1:0] interval_q;
  logic                            err_q;

  logic valid_q, valid_d;
  logic fired_q, fired_d;
  logic error_q, error_d;

  logic                        accept;
  logic                        key_bad;
  logic                        ram_we;
  logic [kelt_pkg::ADDR_W-1:0] ram_waddr;
  kelt_pkg::entry_t            ram_wdata;
  kelt_pkg::entry_t            rd_entry;
  logic [kelt_pkg::ENTRY_W-1:0] ram_rdata;
  logic [kelt_pkg::TIME_W-1:0] elapsed;
  logic                        throttled;
  logic                        hit;

  assign accept  = start && !busy;
  assign key_bad = ({1'b0, key_i} >= (kelt_pkg::KEY_W + 1)'(kelt_pkg::KEYS));

  // key table
  kelt_ram #(
    .Width (kelt_pkg::ENTRY_W),
    .Depth (kelt_pkg::KEYS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (key_i[kelt_pkg::ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  assign rd_entry = kelt_pkg::entry_t'(ram_rdata);

  // throttle and fire decision on the entry read back
  assign elapsed   = now_q - rd_entry.fire_time;
  assign throttled = elapsed < {{(kelt_pkg::TIME_W - kelt_pkg::INTERVAL_W){1'b0}}, interval_q};
  assign hit       = edge_q ? rd_entry.sticky : rd_entry.held;

  // sequencer, read-modify-write and result
  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    now_d     = now_q;
    valid_d   = 1'b0;
    fired_d   = fired_q;
    error_d   = error_q;
    ram_we    = 1'b0;
    ram_waddr = addr_q;
    ram_wdata = rd_entry;

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = '0;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == kelt_pkg::ADDR_W'(kelt_pkg::KEYS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
          if (kelt_pkg::op_e'(op_i) == kelt_pkg::OP_TICK) begin
            now_d = now_q + 1'b1;
          end
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
        valid_d = 1'b1;
        fired_d = 1'b0;
        error_d = err_q;
        if (!err_q) begin
          case (op_q)
            kelt_pkg::OP_PRESS: begin
              ram_we           = 1'b1;
              ram_wdata.held   = 1'b1;
              ram_wdata.sticky = 1'b1;
            end
            kelt_pkg::OP_RELEASE: begin
              ram_we         = 1'b1;
              ram_wdata.held = 1'b0;
            end
            kelt_pkg::OP_CHECK: begin
              if (!throttled) begin
                ram_we           = 1'b1;
                ram_wdata.sticky = 1'b0;
                if (hit) begin
                  ram_wdata.fire_time = now_q;
                end
                fired_d = hit;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
      now_q     <= '0;
      valid_q   <= 1'b0;
      fired_q   <= 1'b0;
      error_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      now_q     <= now_d;
      valid_q   <= valid_d;
      fired_q   <= fired_d;
      error_q   <= error_d;
    end
  end

  // command capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q       <= kelt_pkg::op_e'(op_i);
      addr_q     <= key_i[kelt_pkg::ADDR_W-1:0];
      edge_q     <= edge_mode_i;
      interval_q <= interval_ticks_i;
      err_q      <= (kelt_pkg::op_e'(op_i) != kelt_pkg::OP_TICK) && key_bad;
    end
  end

  assign busy    = (state_q != ST_IDLE);
  assign valid_o = valid_q;
  assign fired_o = fired_q;
  assign error_o = error_q;

endmodule

// ----- sv/kelt_checker.sv -----
// port-level checks for the key event latch/throttle core, bound to the top
// depends on kelt_pkg and key_event_latch_throttle_core_defines.svh
`include "key_event_latch_throttle_core_defines.svh"

module kelt_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start,
  input logic                            busy,
  input logic [1:0]                      op_i,
  input logic [kelt_pkg::KEY_W-1:0]      key_i,
  input logic                            edge_mode_i,
  input logic [kelt_pkg::INTERVAL_W-1:0] interval_ticks_i,
  input logic                            valid_o,
  input logic                            fired_o,
  input logic                            error_o
);

  logic accept;
  logic key_bad;
  logic is_tick;

  assign accept  = start && !busy;
  assign is_tick = (kelt_pkg::op_e'(op_i) == kelt_pkg::OP_TICK);
  assign key_bad = ({1'b0, key_i} >= (kelt_pkg::KEY_W + 1)'(kelt_pkg::KEYS))
                   && (edge_mode_i || !edge_mode_i) && (interval_ticks_i == interval_ticks_i);

  // every transfer is followed by a result strobe
  `KELT_ASSERT(a_result_after_transfer, accept |-> ##2 valid_o, "missing result after transfer")

  // result strobe lasts a single cycle, also across reset
  `KELT_ASSERT_ALWAYS(a_strobe_single, valid_o |=> !valid_o, "result strobe longer than one cycle")

  // an out-of-range key on a keyed command flags an error and never fires
  `KELT_ASSERT(a_bad_key_error, (accept && !is_tick && key_bad) |-> ##2 (error_o && !fired_o),
               "bad key not flagged")

  // a tick never fires nor errors
  `KELT_ASSERT(a_tick_quiet, (accept && is_tick) |-> ##2 (!error_o && !fired_o),
               "tick gave a nonzero result")

  // the core is busy right after a transfer
  `KELT_ASSERT(a_busy_after_transfer, accept |=> busy, "new command taken during execution")

endmodule

bind key_event_latch_throttle_core kelt_checker u_kelt_checker (.*);
